@@ hdl/psraa_pkg.sv @@
package psraa_pkg;

    localparam int SUM_W  = 48;
    localparam int CNT_W  = 32;
    localparam int TIME_W = 32;
    localparam int TEMP_W = 16;
    localparam int QUO_W  = SUM_W;
    localparam int DIV_STEPS = QUO_W;
    localparam int DCNT_W = $clog2(DIV_STEPS + 1);

    // Configuration register indexes.
    localparam logic [1:0] CFG_WINDOW = 2'd0;
    localparam logic [1:0] CFG_COLD   = 2'd1;
    localparam logic [1:0] CFG_HOT    = 2'd2;

    localparam logic [31:0]        WINDOW_RST = 32'd60;
    localparam logic signed [15:0] COLD_RST   = 16'sd100;
    localparam logic signed [15:0] HOT_RST    = 16'sd300;

    typedef enum logic [1:0] {
        STS_NORMAL  = 2'd0,
        STS_COLD    = 2'd1,
        STS_HOT     = 2'd2,
        STS_INVALID = 2'd3
    } t_status;

    // One entry of the per-sensor store.
    typedef struct packed {
        logic signed [SUM_W-1:0] sum;
        logic [CNT_W-1:0]        cnt;
        logic [TIME_W-1:0]       last;
    } t_entry;

    typedef enum logic [2:0] {
        STEP_FETCH  = 3'd0,
        STEP_READ   = 3'd1,
        STEP_UPDATE = 3'd2,
        STEP_DIV    = 3'd3,
        STEP_FINISH = 3'd4,
        STEP_WAIT   = 3'd5,
        STEP_OUT    = 3'd6
    } t_step;

    typedef enum logic [2:0] {
        COND_NEXT,
        COND_ALWAYS,
        COND_NO_INPUT,
        COND_INVALID,
        COND_DIV_MORE,
        COND_OUT_BUSY
    } t_cond;

    typedef struct packed {
        t_cond cond;
        t_step target;
        logic  ld_in;
        logic  rd;
        logic  upd;
        logic  div_step;
        logic  finish;
        logic  ld_out;
    } t_ctl;

    // Microprogram: one control word per step.
    function automatic t_ctl ucode(input t_step s);
        t_ctl c;
        c = '{cond: COND_NEXT, target: STEP_FETCH, default: 1'b0};
        case (s)
            STEP_FETCH: begin
                c.cond   = COND_NO_INPUT;
                c.target = STEP_FETCH;
                c.ld_in  = 1'b1;
            end
            STEP_READ: begin
                c.cond   = COND_INVALID;
                c.target = STEP_WAIT;
                c.rd     = 1'b1;
            end
            STEP_UPDATE: begin
                c.upd = 1'b1;
            end
            STEP_DIV: begin
                c.cond     = COND_DIV_MORE;
                c.target   = STEP_DIV;
                c.div_step = 1'b1;
            end
            STEP_FINISH: begin
                c.finish = 1'b1;
            end
            STEP_WAIT: begin
                c.cond   = COND_OUT_BUSY;
                c.target = STEP_WAIT;
            end
            STEP_OUT: begin
                c.cond   = COND_ALWAYS;
                c.target = STEP_FETCH;
                c.ld_out = 1'b1;
            end
            default: begin
                c.cond   = COND_ALWAYS;
                c.target = STEP_FETCH;
            end
        endcase
        return c;
    endfunction

endpackage

@@ hdl/psraa_ram.sv @@
module psraa_ram #(
    parameter int WIDTH = 112,
    parameter int DEPTH = 16,
    parameter int AW    = 4
) (
    input  logic             i_clk,
    input  logic             i_we,
    input  logic [AW-1:0]    i_waddr,
    input  logic [WIDTH-1:0] i_wdata,
    input  logic [AW-1:0]    i_raddr,
    output logic [WIDTH-1:0] o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        o_rdata <= r_mem[i_raddr];
    end

endmodule

@@ hdl/per_sensor_running_average_alarm.sv @@
// Per-sensor running average with a temperature alarm.
// Input channel: i_valid / o_stall carry one sample item (sensor id, signed
// temperature in tenths of a degree, sample time, current time). Output channel:
// o_valid / i_stall carry one result item per sample (echoed id, average
// truncated toward zero, status). An item moves at a rising edge where valid is
// high and stall is low.
// A small microprogram steps a plain datapath: fetch, store read, update and
// write-back, a restoring divider that produces one quotient bit per cycle,
// finish (sign and alarm compare), and output load. A valid sample passes
// through fetch, read, update, the divider loop, finish, wait and output load
// before the next sample is accepted; a sample with an invalid id goes from
// the read step straight to the wait step and then to the output load.
// The output register lets a finished result wait while the next sample is
// taken and worked on; if the receiver still stalls when that next result is
// ready, the sequencer holds in its wait step until the register frees up.
// Reset is synchronous and active low. It clears the per-sensor valid bits, so
// every sensor reads as zero sum, count and last time, and loads the register
// defaults: reset window 60 s, cold limit 10.0, hot limit 30.0 degrees.
// Configuration writes are taken at any edge with i_cfg_we high.
module per_sensor_running_average_alarm #(
    parameter int SENSOR_COUNT = 16
) (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    input  logic                        i_cfg_we,
    input  logic [1:0]                  i_cfg_index,
    input  logic [31:0]                 i_cfg_data,
    input  logic                        i_valid,
    output logic                        o_stall,
    input  logic [7:0]                  i_sensor_id,
    input  logic signed [15:0]          i_temperature,
    input  logic [31:0]                 i_sample_time,
    input  logic [31:0]                 i_now_time,
    output logic                        o_valid,
    input  logic                        i_stall,
    output logic [7:0]                  o_sensor_echo,
    output logic signed [15:0]          o_average,
    output psraa_pkg::t_status          o_status
);

    import psraa_pkg::*;

    localparam int IDX_W = (SENSOR_COUNT > 1) ? $clog2(SENSOR_COUNT) : 1;

    // Configuration registers.
    logic [31:0]        r_window;
    logic signed [15:0] r_cold;
    logic signed [15:0] r_hot;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_window <= WINDOW_RST;
            r_cold   <= COLD_RST;
            r_hot    <= HOT_RST;
        end else if (i_cfg_we) begin
            case (i_cfg_index)
                CFG_WINDOW: r_window <= i_cfg_data;
                CFG_COLD:   r_cold   <= i_cfg_data[15:0];
                CFG_HOT:    r_hot    <= i_cfg_data[15:0];
                default:    ;
            endcase
        end
    end

    // Sequencer: the step counter addresses the microcode table.
    t_step r_step;
    t_step n_step;
    t_ctl  ctl;
    logic  cond_hit;

    logic [DCNT_W-1:0] r_dcnt;
    logic              r_out_valid;
    logic              r_bad;
    logic              out_busy;
    logic              accept;

    assign ctl      = ucode(r_step);
    assign out_busy = r_out_valid && i_stall;
    assign o_stall  = !ctl.ld_in;
    assign accept   = i_valid && ctl.ld_in;

    always_comb begin
        case (ctl.cond)
            COND_NEXT:     cond_hit = 1'b0;
            COND_ALWAYS:   cond_hit = 1'b1;
            COND_NO_INPUT: cond_hit = !i_valid;
            COND_INVALID:  cond_hit = r_bad;
            COND_DIV_MORE: cond_hit = (r_dcnt != DCNT_W'(1));
            COND_OUT_BUSY: cond_hit = out_busy;
            default:       cond_hit = 1'b1;
        endcase
        n_step = cond_hit ? ctl.target : t_step'(r_step + 3'd1);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_step <= STEP_FETCH;
        end else begin
            r_step <= n_step;
        end
    end

    // Latched sample.
    logic [7:0]         r_id;
    logic signed [15:0] r_temp;
    logic [31:0]        r_stime;
    logic [31:0]        r_now;

    always_ff @(posedge i_clk) begin
        if (accept) begin
            r_id    <= i_sensor_id;
            r_temp  <= i_temperature;
            r_stime <= i_sample_time;
            r_now   <= i_now_time;
            r_bad   <= !({1'b0, i_sensor_id} < 9'(SENSOR_COUNT));
        end
    end

    // Per-sensor store. An entry whose valid bit is clear reads as all zero.
    logic [SENSOR_COUNT-1:0] r_entry_ok;
    logic                    r_hit;
    logic [IDX_W-1:0]        addr;
    logic                    ram_we;
    t_entry                  rd_raw;
    t_entry                  cur;
    t_entry                  nxt;

    assign addr   = r_id[IDX_W-1:0];
    assign ram_we = ctl.upd;

    psraa_ram #(
        .WIDTH ($bits(t_entry)),
        .DEPTH (SENSOR_COUNT),
        .AW    (IDX_W)
    ) u_store (
        .i_clk   (i_clk),
        .i_we    (ram_we),
        .i_waddr (addr),
        .i_wdata (nxt),
        .i_raddr (addr),
        .o_rdata (rd_raw)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_entry_ok <= '0;
        end else if (ram_we) begin
            r_entry_ok[addr] <= 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (ctl.rd) begin
            r_hit <= r_entry_ok[addr];
        end
    end

    assign cur = r_hit ? rd_raw : '0;

    // Update rule: restart when the current time lies more than the window
    // past the last sample; otherwise add, unless the count is saturated.
    logic [32:0] age;
    logic        restart;
    logic        saturated;

    assign age       = {1'b0, r_now} - {1'b0, cur.last};
    assign restart   = !age[32] && (age[31:0] > r_window);
    assign saturated = &cur.cnt;

    always_comb begin
        nxt = cur;
        if (restart) begin
            nxt.sum  = SUM_W'(r_temp);
            nxt.cnt  = CNT_W'(1);
            nxt.last = r_stime;
        end else if (!saturated) begin
            nxt.sum  = cur.sum + SUM_W'(r_temp);
            nxt.cnt  = cur.cnt + CNT_W'(1);
            nxt.last = r_stime;
        end
    end

    // Restoring divider on magnitudes: one quotient bit per cycle. The
    // dividend register shifts out its top bit and takes in the quotient bit.
    logic [QUO_W-1:0] r_quo;
    logic [CNT_W-1:0] r_rem;
    logic [CNT_W-1:0] r_dvs;
    logic             r_neg;
    logic [CNT_W:0]   rem_sh;
    logic [CNT_W+1:0] rem_sub;
    logic             fits;

    assign rem_sh  = {r_rem, r_quo[QUO_W-1]};
    assign rem_sub = {1'b0, rem_sh} - {2'b0, r_dvs};
    assign fits    = !rem_sub[CNT_W+1];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_dcnt <= '0;
        end else if (ctl.upd) begin
            r_dcnt <= DCNT_W'(DIV_STEPS);
        end else if (ctl.div_step) begin
            r_dcnt <= r_dcnt - DCNT_W'(1);
        end
    end

    always_ff @(posedge i_clk) begin
        if (ctl.upd) begin
            r_neg <= nxt.sum[SUM_W-1];
            r_quo <= nxt.sum[SUM_W-1] ? QUO_W'(-nxt.sum) : QUO_W'(nxt.sum);
            r_rem <= '0;
            r_dvs <= nxt.cnt;
        end else if (ctl.div_step) begin
            r_rem <= fits ? rem_sub[CNT_W-1:0] : rem_sh[CNT_W-1:0];
            r_quo <= {r_quo[QUO_W-2:0], fits};
        end
    end

    // Finish: restore the sign and compare against the alarm limits. The
    // average always fits in 16 signed bits, so 17 bits cover the negation.
    logic signed [16:0] avg17;
    logic signed [15:0] r_avg;
    t_status            r_sts;

    assign avg17 = r_neg ? -$signed(r_quo[16:0]) : $signed(r_quo[16:0]);

    always_ff @(posedge i_clk) begin
        if (ctl.finish) begin
            r_avg <= avg17[15:0];
            if (avg17 < 17'(r_cold)) begin
                r_sts <= STS_COLD;
            end else if (avg17 > 17'(r_hot)) begin
                r_sts <= STS_HOT;
            end else begin
                r_sts <= STS_NORMAL;
            end
        end
    end

    // Output register.
    logic load_out;

    assign load_out = ctl.ld_out;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (load_out) begin
            r_out_valid <= 1'b1;
        end else if (!i_stall) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (load_out) begin
            o_sensor_echo <= r_id;
            o_average     <= r_bad ? 16'sd0 : r_avg;
            o_status      <= r_bad ? STS_INVALID : r_sts;
        end
    end

    assign o_valid = r_out_valid;

    // A sample is taken only when the sequencer waits for one, so the block
    // stalls right after taking it.
    a_stall_after_accept : assert property (@(posedge i_clk) disable iff (!i_rst_n)
        accept |=> o_stall)
        else $error("input accepted twice in a row");

    // The store is written only for a valid id.
    a_write_valid_id : assert property (@(posedge i_clk) disable iff (!i_rst_n)
        ram_we |-> !r_bad)
        else $error("store written for an invalid id");

    // A new result never overwrites one that the receiver has not taken.
    a_no_overwrite : assert property (@(posedge i_clk) disable iff (!i_rst_n)
        load_out |-> !out_busy)
        else $error("output register overwritten while stalled");

    // The divider loop only runs with bits left to produce.
    a_div_count : assert property (@(posedge i_clk) disable iff (!i_rst_n)
        ctl.div_step |-> (r_dcnt != '0))
        else $error("divider stepped past its last bit");

    // After a write-back the entry reads as valid.
    a_entry_marked : assert property (@(posedge i_clk) disable iff (!i_rst_n)
        ram_we |=> r_entry_ok[$past(addr)])
        else $error("store entry not marked valid after write");

endmodule
